FILE: design/relative_neighborhood_edge_test_macros.svh
// Assertion macros for the relative neighborhood edge test block.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef RELATIVE_NEIGHBORHOOD_EDGE_TEST_MACROS_SVH
`define RELATIVE_NEIGHBORHOOD_EDGE_TEST_MACROS_SVH

// same-cycle implication, disabled during reset
`define RNET_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rnet assertion failed");

// next-cycle implication, disabled during reset
`define RNET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rnet assertion failed");

`endif

FILE: design/rnet_pkg.sv
// Shared types and constants of the relative neighborhood edge test block.
// No dependencies.
package rnet_pkg;

    localparam int NODE_W   = 6;
    localparam int DIST_W   = 18;
    localparam int COUNT_W  = 7;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd20;

    // register index of node_count in the configuration map
    localparam logic REG_NODE_COUNT = 1'b0;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              op;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [DIST_W-1:0] distance;
    } t_in_item;

    typedef struct packed {
        logic              is_edge;
        logic              bad_query;
        logic [NODE_W-1:0] pair_a;
        logic [NODE_W-1:0] pair_b;
    } t_out_item;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic load;   // capture d(a,b) from read port 0
        logic check;  // read data for a scanned node is present
        logic skip;   // scanned node is one of the pair ends
    } t_cmp_ctl;

endpackage

FILE: design/rnet_dist_ram.sv
// Distance store: one write port, two registered read ports.
// Depends on nothing.
module rnet_dist_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 18
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr0,
    input  logic [ADDR_W-1:0] i_raddr1,
    output logic [DATA_W-1:0] o_rdata0,
    output logic [DATA_W-1:0] o_rdata1
);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [DATA_W-1:0] r_rdata0;
    logic [DATA_W-1:0] r_rdata1;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, data registered
    always_ff @(posedge i_clk) begin
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

FILE: design/rnet_blk_cmp.sv
// Shared blocker compare: holds d(a,b) and tests both distances of a node.
// Depends on rnet_pkg.
module rnet_blk_cmp
    import rnet_pkg::*;
#(
    parameter int DIST_BITS = 18
) (
    input  logic                 i_clk,
    input  t_cmp_ctl             i_ctl,
    input  logic [DIST_BITS-1:0] i_d_ab,
    input  logic [DIST_BITS-1:0] i_d_ak,
    input  logic [DIST_BITS-1:0] i_d_bk,
    output logic                 o_blocked
);

    logic [DIST_BITS-1:0] r_dab;
    logic [DIST_BITS-1:0] n_dab;

    // pair distance, captured once per query
    always_comb begin
        n_dab = r_dab;
        if (i_ctl.load) begin
            n_dab = i_d_ab;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dab <= n_dab;
    end

    // node k blocks when strictly closer to both ends
    assign o_blocked = i_ctl.check && !i_ctl.skip && (i_d_ak < r_dab) && (i_d_bk < r_dab);

endmodule

FILE: design/relative_neighborhood_edge_test.sv
// Relative neighborhood edge test over a stored pairwise distance table.
// Write: the distance goes to entries (a,b) and (b,a) in states S_WRA and S_WRB; no result.
// Query: states S_QRD, S_QDAB, S_SCAN and S_DONE scan the nodes below limit (limit = min(node_count, MAX_NODES)),
//   ending early on a blocker and going from S_QRD straight to S_DONE on a bad query; one node per cycle through the
//   two read ports of the distance memory and the shared compare unit.
// Reset clears control and sets node_count to 20; the distance memory is not cleared.
`include "relative_neighborhood_edge_test_macros.svh"

module relative_neighborhood_edge_test
    import rnet_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int DIST_BITS = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int DEPTH  = MAX_NODES * MAX_NODES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_NODES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WRA  = 3'd1;
    localparam logic [2:0] S_WRB  = 3'd2;
    localparam logic [2:0] S_QRD  = 3'd3;
    localparam logic [2:0] S_QDAB = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [COUNT_W-1:0] r,
                                                  input logic [COUNT_W-1:0] c);
        addr_of = ADDR_W'(r) * ROW_STRIDE + ADDR_W'(c);
    endfunction

    logic [2:0]         r_state, n_state;
    t_in_item           r_item, n_item;
    logic [COUNT_W-1:0] r_node_count, n_node_count;
    logic [COUNT_W-1:0] r_k, n_k;
    logic [COUNT_W-1:0] r_pk, n_pk;
    logic               r_pend, n_pend;
    logic               r_edge, n_edge;
    logic               r_bad, n_bad;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] node_a_x;
    logic [COUNT_W-1:0] node_b_x;
    logic               wr_in_range;
    logic               cfg_write;
    logic               in_xfer;
    logic               out_free;
    logic               issue;
    logic               blocked;
    t_cmp_ctl           cmp_ctl;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [DIST_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr0;
    logic [ADDR_W-1:0]    mem_raddr1;
    logic [DIST_BITS-1:0] mem_rdata0;
    logic [DIST_BITS-1:0] mem_rdata1;

    // node limit and pair range checks
    assign limit       = (32'(r_node_count) > MAX_NODES) ? COUNT_W'(MAX_NODES) : r_node_count;
    assign node_a_x    = {1'b0, r_item.node_a};
    assign node_b_x    = {1'b0, r_item.node_b};
    assign wr_in_range = (32'(r_item.node_a) < MAX_NODES) && (32'(r_item.node_b) < MAX_NODES);

    // handshakes
    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cfg_write  = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
    assign issue      = (r_k < limit);

    // configuration read
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_COUNT) ? PDATA_W'(r_node_count) : '0;

    // memory port steering
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = addr_of(node_a_x, node_b_x);
        mem_wdata  = DIST_BITS'(r_item.distance);
        mem_raddr0 = addr_of(node_a_x, r_k);
        mem_raddr1 = addr_of(node_b_x, r_k);
        case (r_state)
            S_WRA: begin
                mem_we = wr_in_range;
            end
            S_WRB: begin
                mem_we    = wr_in_range;
                mem_waddr = addr_of(node_b_x, node_a_x);
            end
            S_QRD: begin
                mem_raddr0 = addr_of(node_a_x, node_b_x);
            end
            default: begin
            end
        endcase
    end

    // compare unit control
    always_comb begin
        cmp_ctl.load  = (r_state == S_QDAB);
        cmp_ctl.check = (r_state == S_SCAN) && r_pend;
        cmp_ctl.skip  = (r_pk == node_a_x) || (r_pk == node_b_x);
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_node_count = r_node_count;
        n_k          = r_k;
        n_pk         = r_pk;
        n_pend       = 1'b0;
        n_edge       = r_edge;
        n_bad        = r_bad;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;

        if (cfg_write) begin
            n_node_count = pwdata[COUNT_W-1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_item  = i_in_data;
                    n_state = (i_in_data.op == OP_WRITE) ? S_WRA : S_QRD;
                end
            end
            S_WRA: begin
                n_state = S_WRB;
            end
            S_WRB: begin
                n_state = S_IDLE;
            end
            S_QRD: begin
                n_bad  = (r_item.node_a == r_item.node_b) || (node_a_x >= limit) ||
                         (node_b_x >= limit);
                n_edge = 1'b0;
                n_k    = '0;
                n_state = n_bad ? S_DONE : S_QDAB;
            end
            S_QDAB: begin
                n_edge  = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (blocked) begin
                    n_edge  = 1'b0;
                    n_state = S_DONE;
                end else if (issue) begin
                    n_pend = 1'b1;
                    n_pk   = r_k;
                    n_k    = r_k + 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.is_edge   = r_edge;
                    n_out.bad_query = r_bad;
                    n_out.pair_a    = r_item.node_a;
                    n_out.pair_b    = r_item.node_b;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= NODE_COUNT_RESET;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_k    <= n_k;
        r_pk   <= n_pk;
        r_edge <= n_edge;
        r_bad  <= n_bad;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    rnet_dist_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DIST_BITS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr0 (mem_raddr0),
        .i_raddr1 (mem_raddr1),
        .o_rdata0 (mem_rdata0),
        .o_rdata1 (mem_rdata1)
    );

    rnet_blk_cmp #(
        .DIST_BITS (DIST_BITS)
    ) u_cmp (
        .i_clk     (i_clk),
        .i_ctl     (cmp_ctl),
        .i_d_ab    (mem_rdata0),
        .i_d_ak    (mem_rdata0),
        .i_d_bk    (mem_rdata1),
        .o_blocked (blocked)
    );

    // checks
    `RNET_ASSERT_NOW(a_scan_bound, r_state == S_SCAN, r_k <= limit)
    `RNET_ASSERT_NOW(a_bad_not_edge, o_out_valid, !(o_out_data.is_edge && o_out_data.bad_query))
    `RNET_ASSERT_NEXT(a_block_ends_scan, (r_state == S_SCAN) && blocked,
                      (r_state == S_DONE) && !r_edge)

endmodule

FILE: tb/sv/tb_relative_neighborhood_edge_test.sv
// Self-checking bench for relative_neighborhood_edge_test: a directed table, then random phases
// over several node counts, with a behavioral edge predictor and random idling on both sides.
// Depends on rnet_pkg and the relative_neighborhood_edge_test RTL.
module tb_relative_neighborhood_edge_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rnet_pkg::*;

    localparam int NODES           = 64;
    localparam int SETTLE_CYCLES   = 80;    // longest query scan plus margin
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int SHOWN_MISMATCH  = 40;

    localparam logic [PADDR_W-1:0] ADDR_NODE_COUNT = PADDR_W'(4 * REG_NODE_COUNT);
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED   = PADDR_W'(4);

    typedef enum logic [1:0] {ROW_ITEM, ROW_REG} t_row_kind;
    // where the expected answer of a query row comes from
    typedef enum logic [1:0] {ANS_MODEL, ANS_BAD, ANS_EDGE} t_answer_src;

    typedef struct packed {
        t_row_kind          kind;
        t_in_item           item;
        t_answer_src        answer;
        logic [PADDR_W-1:0] reg_addr;
        logic [COUNT_W-1:0] reg_value;
    } t_dir_row;

    // directed table: bad pairs at reset count, a three-node set with extreme and tied
    // distances, the unmapped register, and node counts 2, 1 and 0
    localparam t_dir_row DIRECTED [30] = '{
        '{ROW_ITEM, '{OP_QUERY, 6'd7,  6'd7,  18'd0},       ANS_BAD,   '0, '0},
        '{ROW_ITEM, '{OP_QUERY, 6'd20, 6'd0,  18'd0},       ANS_BAD,   '0, '0},
        '{ROW_ITEM, '{OP_QUERY, 6'd0,  6'd63, 18'h3FFFF},   ANS_BAD,   '0, '0},
        '{ROW_ITEM, '{OP_QUERY, 6'd63, 6'd62, 18'h2AAAA},   ANS_BAD,   '0, '0},
        '{ROW_REG,  '0,                                     ANS_MODEL, ADDR_NODE_COUNT, 7'd3},
        '{ROW_ITEM, '{OP_WRITE, 6'd0,  6'd1,  18'h3FFFF},   ANS_MODEL, '0, '0},
        '{ROW_ITEM, '{OP_WRITE, 6'd2,  6'd0,  18'd0},       ANS_MODEL, '0, '0},
        '{ROW_ITEM, '{OP_WRITE, 6'd1,  6'd2,  18'd0},       ANS_MODEL, '0, '0},
        '{ROW_ITEM, '{OP_WRITE, 6'd1,  6'd1,  18'd5},       ANS_MODEL, '0, '0},
        '{ROW_ITEM, '{OP_QUERY, 6'd0,  6'd1,  18'd0},       ANS_MODEL, '0, '0},
        '{ROW_ITEM, '{OP_QUERY, 6'd2,  6'd0,  18'd0},       ANS_MODEL, '0, '0},
        '{ROW_ITEM, '{OP_QUERY, 6'd1,  6'd2,  18'd0},       ANS_MODEL, '0, '0},
        '{ROW_ITEM, '{OP_QUERY, 6'd0,  6'd3,  18'd0},       ANS_BAD,   '0, '0},
        '{ROW_ITEM, '{OP_WRITE, 6'd0,  6'd2,  18'd7},       ANS_MODEL, '0, '0},
        '{ROW_ITEM, '{OP_WRITE, 6'd1,  6'd2,  18'd7},       ANS_MODEL, '0, '0},
        '{ROW_ITEM, '{OP_WRITE, 6'd0,  6'd1,  18'd7},       ANS_MODEL, '0, '0},
        '{ROW_ITEM, '{OP_QUERY, 6'd1,  6'd0,  18'd0},       ANS_MODEL, '0, '0},
        '{ROW_REG,  '0,                                     ANS_MODEL, ADDR_UNMAPPED, 7'd5},
        '{ROW_ITEM, '{OP_QUERY, 6'd0,  6'd2,  18'd0},       ANS_MODEL, '0, '0},
        '{ROW_REG,  '0,                                     ANS_MODEL, ADDR_NODE_COUNT, 7'd2},
        '{ROW_ITEM, '{OP_QUERY, 6'd1,  6'd0,  18'd0},       ANS_EDGE,  '0, '0},
        '{ROW_ITEM, '{OP_QUERY, 6'd0,  6'd2,  18'd0},       ANS_BAD,   '0, '0},
        '{ROW_REG,  '0,                                     ANS_MODEL, ADDR_NODE_COUNT, 7'd1},
        '{ROW_ITEM, '{OP_QUERY, 6'd0,  6'd1,  18'd0},       ANS_BAD,   '0, '0},
        '{ROW_REG,  '0,                                     ANS_MODEL, ADDR_NODE_COUNT, 7'd0},
        '{ROW_ITEM, '{OP_QUERY, 6'd1,  6'd0,  18'd0},       ANS_BAD,   '0, '0},
        '{ROW_ITEM, '{OP_WRITE, 6'd63, 6'd62, 18'h2AAAA},   ANS_MODEL, '0, '0},
        '{ROW_ITEM, '{OP_WRITE, 6'd62, 6'd63, 18'h15555},   ANS_MODEL, '0, '0},
        '{ROW_ITEM, '{OP_QUERY, 6'd62, 6'd63, 18'd0},       ANS_BAD,   '0, '0},
        '{ROW_ITEM, '{OP_QUERY, 6'd0,  6'd0,  18'd0},       ANS_BAD,   '0, '0}
    };

    // DUT pins
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // predictor state: distance table, which entries were written, node count register
    logic [DIST_W-1:0]  dist_table   [NODES][NODES];
    bit                 dist_written [NODES][NODES];
    logic [COUNT_W-1:0] node_limit = NODE_COUNT_RESET;
    t_out_item          pending_answers [$];

    int  mismatches  = 0;
    int  items_sent  = 0;
    int  idle_cycles = 0;
    bit  backpressure_req  = 1'b0;
    bit  backpressure_done = 1'b0;

    relative_neighborhood_edge_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < SHOWN_MISMATCH) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    // nodes taking part in a scan; counts above the table size saturate
    function automatic int unsigned active_nodes();
        return (node_limit > NODES) ? NODES : node_limit;
    endfunction

    // edge answer for a query, scanning every other node in use
    function automatic t_out_item rng_answer(input t_in_item item);
        t_out_item         ans;
        int unsigned       lim;
        logic [DIST_W-1:0] span;
        lim = active_nodes();
        ans.pair_a    = item.node_a;
        ans.pair_b    = item.node_b;
        ans.is_edge   = 1'b0;
        ans.bad_query = (item.node_a == item.node_b) || (item.node_a >= lim)
                        || (item.node_b >= lim);
        if (!ans.bad_query) begin
            span = dist_table[item.node_a][item.node_b];
            ans.is_edge = 1'b1;
            for (int k = 0; k < lim; k++) begin
                if (k != item.node_a && k != item.node_b
                    && dist_table[item.node_a][k] < span
                    && dist_table[item.node_b][k] < span) begin
                    ans.is_edge = 1'b0;
                end
            end
        end
        return ans;
    endfunction

    function automatic logic [DIST_W-1:0] rand_distance();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            2, 3:    return DIST_W'($urandom);
            default: return DIST_W'($urandom_range(0, 15));  // small values force ties
        endcase
    endfunction

    // hub > 0 keeps the picked node among the first hub nodes (when hub < lim), so rows fill quickly
    function automatic logic [NODE_W-1:0] pick_node(input int unsigned lim, input int hub);
        int unsigned top;
        top = (hub != 0 && hub < lim) ? hub : lim;
        return (top == 0) ? '0 : NODE_W'($urandom_range(0, top - 1));
    endfunction

    function automatic t_in_item next_item(input int hub);
        t_in_item          item;
        int unsigned       lim;
        int                roll;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        lim = active_nodes();
        roll = $urandom_range(0, 99);
        item.distance = rand_distance();
        if (roll < 10) begin
            // noise: any op, any nodes
            item.op     = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_QUERY;
            item.node_a = NODE_W'($urandom_range(0, NODES - 1));
            item.node_b = NODE_W'($urandom_range(0, NODES - 1));
        end else if (roll < 40 || lim == 0) begin
            item.op     = OP_WRITE;
            item.node_a = pick_node(lim, hub);
            item.node_b = pick_node(lim, 0);
        end else begin
            item.op     = OP_QUERY;
            item.node_a = pick_node(lim, hub);
            item.node_b = pick_node(lim, hub);
        end
        a = item.node_a;
        b = item.node_b;
        // a scan must never touch an unwritten entry: write the first missing one instead
        if (item.op == OP_QUERY && a != b && a < lim && b < lim) begin
            if (!dist_written[a][b]) begin
                item.op = OP_WRITE;
            end else begin
                for (int k = 0; k < lim; k++) begin
                    if (k != a && k != b && (!dist_written[a][k] || !dist_written[b][k])) begin
                        item.op     = OP_WRITE;
                        item.node_a = dist_written[a][k] ? b : a;
                        item.node_b = NODE_W'(k);
                        break;
                    end
                end
            end
        end
        return item;
    endfunction

    // sender gaps: stretches of 40 transfers without gaps alternate with gappy ones
    function automatic int sender_gap();
        if (((items_sent / 40) % 2) == 1 || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // offer one item, hold it until the transfer, then update the predictor
    task automatic send_item(input t_in_item item, input t_answer_src answer);
        int        gap;
        t_out_item want;
        gap = sender_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (item.op == OP_WRITE) begin
            dist_table[item.node_a][item.node_b]   = item.distance;
            dist_table[item.node_b][item.node_a]   = item.distance;
            dist_written[item.node_a][item.node_b] = 1'b1;
            dist_written[item.node_b][item.node_a] = 1'b1;
        end else begin
            want = rng_answer(item);
            if (answer != ANS_MODEL) begin
                want.is_edge   = (answer == ANS_EDGE);
                want.bad_query = (answer == ANS_BAD);
            end
            pending_answers.push_back(want);
        end
    endtask

    // drop valid, wait for every answer, then let a trailing write finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup then access phase; psel stays up so accesses can run back to back
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
    endtask

    // register write while idle, followed by a read-back of node_count
    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [COUNT_W-1:0] value);
        logic [PDATA_W-1:0] rdata;
        settle();
        apb_access(1'b1, addr, PDATA_W'(value), rdata);
        if (addr == ADDR_NODE_COUNT) begin
            node_limit = value;
        end
        apb_access(1'b0, ADDR_NODE_COUNT, '0, rdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (rdata !== PDATA_W'(node_limit)) begin
            report_mismatch($sformatf("node_count reads %0h, expected %0h", rdata, node_limit));
        end
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] count, input int n_items,
                             input int hub, input bit with_hold);
        reg_write(ADDR_NODE_COUNT, count);
        if (with_hold) begin
            backpressure_req = 1'b1;
        end
        repeat (n_items) send_item(next_item(hub), ANS_MODEL);
    endtask

    // result side: random stall, one long hold-off on request
    initial begin : result_sink
        int span;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (backpressure_req && !backpressure_done) begin
                backpressure_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if ($urandom_range(0, 1) == 0) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                span = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(1, 3);
                repeat (span) @(posedge i_clk);
            end
        end
    end

    // compare each result transfer with the oldest pending answer
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("result %h with no query pending", o_out_data));
            end else begin
                want = pending_answers.pop_front();
                if (o_out_data.is_edge !== want.is_edge) begin
                    report_mismatch($sformatf("pair %0d,%0d is_edge %b, expected %b",
                        want.pair_a, want.pair_b, o_out_data.is_edge, want.is_edge));
                end
                if (o_out_data.bad_query !== want.bad_query) begin
                    report_mismatch($sformatf("pair %0d,%0d bad_query %b, expected %b",
                        want.pair_a, want.pair_b, o_out_data.bad_query, want.bad_query));
                end
                if (o_out_data.pair_a !== want.pair_a) begin
                    report_mismatch($sformatf("pair_a %0d, expected %0d",
                        o_out_data.pair_a, want.pair_a));
                end
                if (o_out_data.pair_b !== want.pair_b) begin
                    report_mismatch($sformatf("pair_b %0d, expected %0d",
                        o_out_data.pair_b, want.pair_b));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_REG) begin
                reg_write(DIRECTED[i].reg_addr, DIRECTED[i].reg_value);
            end else begin
                send_item(DIRECTED[i].item, DIRECTED[i].answer);
            end
        end

        // random phases; large counts query only among a few hub nodes
        run_phase(7'd3, 60, 0, 1'b0);
        run_phase(COUNT_W'($urandom_range(4, 10)), 80, 0, 1'b1);
        run_phase(COUNT_W'($urandom_range(11, 24)), 90, 5, 1'b0);
        run_phase(7'd64, 320, 4, 1'b0);
        run_phase(7'd127, 40, 4, 1'b0);
        run_phase(7'd2, 20, 0, 1'b0);
        run_phase(COUNT_W'($urandom_range(25, 63)), 60, 4, 1'b0);
        run_phase(COUNT_W'($urandom_range(3, 16)), 100, 0, 1'b0);

        settle();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/rnet_pkg.sv
design/rnet_dist_ram.sv
design/rnet_blk_cmp.sv
design/relative_neighborhood_edge_test.sv
tb/sv/tb_relative_neighborhood_edge_test.sv
